// ----- sv/cfpr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfpr_pkg
// Shared types, constants and helpers of the CAN capture record serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpr_pkg;

  localparam logic [31:0] ERR_FLAG = 32'h2000_0000;
  localparam logic [31:0] EFF_FLAG = 32'h8000_0000;
  localparam logic [31:0] RTR_FLAG = 32'h4000_0000;
  localparam logic [31:0] SFF_MASK = 32'h0000_07FF;
  localparam logic [31:0] EFF_MASK = 32'h1FFF_FFFF;

  // one million = 64 * 15625; reciprocal of 15625 scaled by 2^44
  localparam logic [13:0] USEC_ODD   = 14'd15625;
  localparam logic [30:0] USEC_RECIP = 31'd1125899907;
  localparam int unsigned USEC_W     = 20;

  localparam logic [7:0] RECLEN_CLASSIC = 8'd16;
  localparam logic [7:0] RECLEN_FD      = 8'd72;

  localparam logic FUNC_HEADER  = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [4:0] HDR_LAST_IDX = 5'd23;
  localparam logic [4:0] PLD_LAST_IDX = 5'd7;

  localparam logic [3:0] WORDS_CLASSIC = 4'd1;
  localparam logic [3:0] WORDS_FD      = 4'd8;

  typedef struct packed {
    logic        hdr;
    logic        last;
    logic        fd;
    logic [63:0] data;
    logic [31:0] canid;
    logic [7:0]  len;
    logic [1:0]  flags;
  } cmd_t;

  function automatic logic [7:0] fd_len(input logic [3:0] dlc);
    logic [7:0] r;
    case (dlc)
      4'd9:    r = 8'd12;
      4'd10:   r = 8'd16;
      4'd11:   r = 8'd20;
      4'd12:   r = 8'd24;
      4'd13:   r = 8'd32;
      4'd14:   r = 8'd48;
      4'd15:   r = 8'd64;
      default: r = {4'd0, dlc};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cfpr_front.sv -----
// ----------------------------------------------------------------------------
// cfpr_front
// Input stage: tracks frame progress, drops stray payload words and builds
// back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_front import cfpr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        func_i,
  input  wire logic [28:0] frame_id_i,
  input  wire logic        extended_id_i,
  input  wire logic        remote_request_i,
  input  wire logic        error_frame_i,
  input  wire logic        fd_frame_i,
  input  wire logic        bit_rate_switch_i,
  input  wire logic        error_state_ind_i,
  input  wire logic [3:0]  dlc_code_i,
  input  wire logic [63:0] timestamp_us_i,
  input  wire logic [63:0] payload_word_i,
  output logic             cmd_push_o,
  output cmd_t             cmd_o
);

  logic       fd_in_progress_q, fd_in_progress_d;
  logic [3:0] words_left_q, words_left_d;
  logic [31:0] id_ext, canid;
  logic        is_hdr;

  assign is_hdr = (func_i == FUNC_HEADER);
  assign id_ext = {3'd0, frame_id_i};

  always_comb begin
    if (error_frame_i) begin
      canid = ERR_FLAG | (id_ext & EFF_MASK);
    end else begin
      canid = extended_id_i ? ((id_ext & EFF_MASK) | EFF_FLAG) : (id_ext & SFF_MASK);
      if (remote_request_i) begin
        canid = canid | RTR_FLAG;
      end
    end
  end

  always_comb begin
    cmd_o.hdr   = is_hdr;
    cmd_o.last  = (words_left_q == WORDS_CLASSIC);
    cmd_o.fd    = fd_frame_i;
    cmd_o.data  = is_hdr ? timestamp_us_i : payload_word_i;
    cmd_o.canid = canid;
    cmd_o.len   = fd_frame_i ? fd_len(dlc_code_i) : {4'd0, dlc_code_i};
    cmd_o.flags = fd_frame_i ? {error_state_ind_i, bit_rate_switch_i} : 2'b00;
  end

  assign cmd_push_o = accept_i && (is_hdr || (words_left_q != 4'd0));

  always_comb begin
    fd_in_progress_d = fd_in_progress_q;
    words_left_d     = words_left_q;
    if (accept_i) begin
      if (is_hdr) begin
        fd_in_progress_d = fd_frame_i;
        words_left_d     = fd_frame_i ? WORDS_FD : WORDS_CLASSIC;
      end else if (words_left_q != 4'd0) begin
        words_left_d = words_left_q - 4'd1;
        if (words_left_q == WORDS_CLASSIC) begin
          fd_in_progress_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_in_progress_q <= 1'b0;
      words_left_q     <= 4'd0;
    end else begin
      fd_in_progress_q <= fd_in_progress_d;
      words_left_q     <= words_left_d;
    end
  end

  a_fd_has_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fd_in_progress_q |-> (words_left_q != 4'd0))
    else $error("fd frame active with no words left");

  a_classic_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fd_in_progress_q |-> (words_left_q <= WORDS_CLASSIC))
    else $error("classic frame expects more than one word");

endmodule

`default_nettype wire

// ----- sv/cfpr_queue.sv -----
// ----------------------------------------------------------------------------
// cfpr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_queue import cfpr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ----- sv/cfpr_div.sv -----
// ----------------------------------------------------------------------------
// cfpr_div
// Timestamp splitter: 64-bit microseconds into seconds and microseconds.
// The low six bits pass through; the rest is divided by 15625 in 16-bit
// digits, each digit by reciprocal multiplication, then a back-multiply remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_div import cfpr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [63:0]       dividend_i,
  output logic                   busy_o,
  output logic [31:0]            sec_o,
  output logic [USEC_W-1:0]      usec_o
);

  logic        busy_q;
  logic [2:0]  cnt_q;
  logic [63:0] num_q;
  logic [31:0] quo_q;
  logic [13:0] rem_q;
  logic [15:0] dig_q;
  logic [5:0]  lo_q;
  logic [29:0] part;
  logic [60:0] prod;
  logic [29:0] back_mul;
  logic [29:0] part_rem;

  // partial dividend: running remainder with the next 16-bit digit
  assign part     = {rem_q, num_q[63:48]};
  assign prod     = 61'(part) * 61'(USEC_RECIP);
  assign back_mul = 30'(dig_q) * 30'(USEC_ODD);
  assign part_rem = part - back_mul;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {6'd0, dividend_i[63:6]};
      lo_q  <= dividend_i[5:0];
      quo_q <= '0;
      rem_q <= '0;
      dig_q <= '0;
    end else if (busy_q) begin
      if (!cnt_q[0]) begin
        dig_q <= prod[59:44];
      end else begin
        num_q <= {num_q[47:0], 16'd0};
        quo_q <= {quo_q[15:0], dig_q};
        rem_q <= part_rem[13:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign sec_o  = quo_q;
  assign usec_o = {rem_q, lo_q};

endmodule

`default_nettype wire

// ----- sv/cfpr_back.sv -----
// ----------------------------------------------------------------------------
// cfpr_back
// Back end: runs the timestamp split for headers and streams record bytes
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_back import cfpr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_record_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  cmd_t              cmd_q;
  logic [4:0]        idx_q, idx_d;
  logic              ov_q;
  logic [7:0]        ob_q;
  logic              eor_q;
  logic              div_busy;
  logic [31:0]       sec;
  logic [USEC_W-1:0] usec;
  logic [31:0]       usec32;
  logic [7:0]        reclen;
  logic              emit, last_idx, load, div_start;
  logic [7:0]        hbyte, pbyte, nbyte;
  logic [63:0]       pshift;

  cfpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (q_cmd_i.data),
    .busy_o     (div_busy),
    .sec_o      (sec),
    .usec_o     (usec)
  );

  assign emit     = (state_q == ST_EMIT) && (!ov_q || pop_i);
  assign last_idx = cmd_q.hdr ? (idx_q == HDR_LAST_IDX) : (idx_q == PLD_LAST_IDX);
  assign load     = !q_empty_i && ((state_q == ST_IDLE) || (emit && last_idx));
  assign q_pop_o  = load;
  assign div_start = load && q_cmd_i.hdr;

  assign usec32 = {{(32 - USEC_W){1'b0}}, usec};
  assign reclen = cmd_q.fd ? RECLEN_FD : RECLEN_CLASSIC;
  assign pshift = cmd_q.data >> {idx_q[2:0], 3'b000};
  assign pbyte  = pshift[7:0];

  always_comb begin
    case (idx_q)
      5'd0:    hbyte = sec[7:0];
      5'd1:    hbyte = sec[15:8];
      5'd2:    hbyte = sec[23:16];
      5'd3:    hbyte = sec[31:24];
      5'd4:    hbyte = usec32[7:0];
      5'd5:    hbyte = usec32[15:8];
      5'd6:    hbyte = usec32[23:16];
      5'd7:    hbyte = usec32[31:24];
      5'd8:    hbyte = reclen;
      5'd12:   hbyte = reclen;
      5'd16:   hbyte = cmd_q.canid[31:24];
      5'd17:   hbyte = cmd_q.canid[23:16];
      5'd18:   hbyte = cmd_q.canid[15:8];
      5'd19:   hbyte = cmd_q.canid[7:0];
      5'd20:   hbyte = cmd_q.len;
      5'd21:   hbyte = {6'd0, cmd_q.flags};
      default: hbyte = 8'd0;
    endcase
  end

  assign nbyte = cmd_q.hdr ? hbyte : pbyte;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = q_cmd_i.hdr ? ST_DIV : ST_EMIT;
          idx_d   = 5'd0;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (last_idx) begin
            idx_d = 5'd0;
            if (load) begin
              state_d = q_cmd_i.hdr ? ST_DIV : ST_EMIT;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_cmd_i;
    end
    if (emit) begin
      ob_q  <= nbyte;
      eor_q <= !cmd_q.hdr && cmd_q.last && last_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 5'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign empty_o         = !ov_q;
  assign out_byte_o      = ob_q;
  assign end_of_record_o = eor_q;

  a_div_idle_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !div_busy)
    else $error("emitting while timestamp split busy");

  a_div_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_DIV) && div_busy)
    else $error("timestamp split start lost");

endmodule

`default_nettype wire

// ----- sv/can_frame_pcap_record_serializer_core.sv -----
// ----------------------------------------------------------------------------
// can_frame_pcap_record_serializer_core
// Turns CAN / CAN FD header and payload items into pcap SocketCAN record
// bytes, one byte per result.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   request  | push / full                | func_i .. payload_word_i
//   result   | empty / pop                | out_byte_o, end_of_record_o
//
// Payload word: 8 bytes, one byte per cycle out of the output register while popped.
// Header: the timestamp split by one million, then 24 bytes.
// A two-entry command queue lets intake run ahead of the byte stream.
// Reset clears frame tracking, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_pcap_record_serializer_core import cfpr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        func_i,
  input  wire logic [28:0] frame_id_i,
  input  wire logic        extended_id_i,
  input  wire logic        remote_request_i,
  input  wire logic        error_frame_i,
  input  wire logic        fd_frame_i,
  input  wire logic        bit_rate_switch_i,
  input  wire logic        error_state_ind_i,
  input  wire logic [3:0]  dlc_code_i,
  input  wire logic [63:0] timestamp_us_i,
  input  wire logic [63:0] payload_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             end_of_record_o
);

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic q_empty, q_pop;
  cmd_t q_cmd;

  assign accept = push && !full;

  cfpr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .func_i            (func_i),
    .frame_id_i        (frame_id_i),
    .extended_id_i     (extended_id_i),
    .remote_request_i  (remote_request_i),
    .error_frame_i     (error_frame_i),
    .fd_frame_i        (fd_frame_i),
    .bit_rate_switch_i (bit_rate_switch_i),
    .error_state_ind_i (error_state_ind_i),
    .dlc_code_i        (dlc_code_i),
    .timestamp_us_i    (timestamp_us_i),
    .payload_word_i    (payload_word_i),
    .cmd_push_o        (cmd_push),
    .cmd_o             (cmd_in)
  );

  cfpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  cfpr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .out_byte_o      (out_byte_o),
    .end_of_record_o (end_of_record_o)
  );

endmodule

`default_nettype wire
